// ===== sv/x86enc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types, form codes and helpers for the IA-32 instruction encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

    localparam int unsigned CodeBytes = 6;

    typedef enum logic [5:0] {
        OP_ADD_RI      = 6'd0,
        OP_ADD         = 6'd1,
        OP_AND         = 6'd2,
        OP_BSF         = 6'd3,
        OP_BSR         = 6'd4,
        OP_CALL_REL    = 6'd5,
        OP_CMP         = 6'd6,
        OP_DIV         = 6'd7,
        OP_IDIV        = 6'd8,
        OP_JAE         = 6'd9,
        OP_JB          = 6'd10,
        OP_JZ          = 6'd11,
        OP_JNE         = 6'd12,
        OP_JMP_REL     = 6'd13,
        OP_MOV_R8_R8   = 6'd14,
        OP_MOV_RR      = 6'd15,
        OP_MOV_DIS_R   = 6'd16,
        OP_MOV_R_DIS   = 6'd17,
        OP_MOV_R_AR    = 6'd18,
        OP_MOV_AR_R8   = 6'd19,
        OP_MOV_AR_R    = 6'd20,
        OP_MOV_RI      = 6'd21,
        OP_MOVSX_AR8   = 6'd22,
        OP_MOVSX_AR16  = 6'd23,
        OP_MOVZX_AR8   = 6'd24,
        OP_MOVZX_AR16  = 6'd25,
        OP_MUL         = 6'd26,
        OP_OR          = 6'd27,
        OP_PUSH        = 6'd28,
        OP_POP         = 6'd29,
        OP_RET         = 6'd30,
        OP_ROL         = 6'd31,
        OP_ROR         = 6'd32,
        OP_SAR         = 6'd33,
        OP_SHR         = 6'd34,
        OP_SHL_IMM     = 6'd35,
        OP_SHL         = 6'd36,
        OP_SETA        = 6'd37,
        OP_SETAE       = 6'd38,
        OP_SETB        = 6'd39,
        OP_SETBE       = 6'd40,
        OP_SETG        = 6'd41,
        OP_SETGE       = 6'd42,
        OP_SETL        = 6'd43,
        OP_SETLE       = 6'd44,
        OP_SETNE       = 6'd45,
        OP_SETZ        = 6'd46,
        OP_SUB_RI      = 6'd47,
        OP_SUB         = 6'd48,
        OP_TEST        = 6'd49,
        OP_XOR         = 6'd50
    } opcode_t;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [2:0]  first_reg;
        logic [2:0]  second_reg;
        logic [31:0] immediate;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [31:0] stack_height;
    } req_t;

    typedef struct packed {
        logic [8*CodeBytes-1:0] code_bytes;
        logic [2:0]             code_length;
        logic [31:0]            stack_height;
    } res_t;

    localparam logic [7:0] PfxTwoByte = 8'h0f;
    localparam logic [7:0] OpNop      = 8'h90;
    localparam logic [1:0] ModInd     = 2'd0;
    localparam logic [1:0] ModDisp32  = 2'd2;
    localparam logic [1:0] ModReg     = 2'd3;
    localparam logic [2:0] RegEbp     = 3'd5;
    localparam logic [2:0] RegEax     = 3'd0;

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                         input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

endpackage
`default_nettype wire

// ===== sv/x86enc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86enc_core
// Combinational byte assembly for one registered encode request.
// ----------------------------------------------------------------------------
module x86enc_core
(
    input  wire x86enc_pkg::req_t req,
    output x86enc_pkg::res_t      res
);

    logic [7:0]  b [x86enc_pkg::CodeBytes];
    logic [2:0]  len;
    logic [31:0] stk;
    logic [31:0] rel;
    logic [31:0] rel5;
    logic [31:0] rel6;
    logic [31:0] imm;
    logic [2:0]  r0;
    logic [2:0]  r1;

    assign imm  = req.immediate;
    assign r0   = req.first_reg;
    assign r1   = req.second_reg;
    assign rel  = req.end_addr - req.start_addr;
    assign rel5 = rel - 32'd5;
    assign rel6 = rel - 32'd6;

    always_comb
    begin
        for (int i = 0; i < x86enc_pkg::CodeBytes; i++)
        begin
            b[i] = 8'h00;
        end
        len = 3'd2;
        stk = req.stack_height;
        unique case (x86enc_pkg::opcode_t'(req.opcode))
            x86enc_pkg::OP_ADD_RI, x86enc_pkg::OP_SUB_RI:
            begin
                if (r0 == x86enc_pkg::RegEax)
                begin
                    b[0] = (req.opcode == x86enc_pkg::OP_ADD_RI) ? 8'h05 : 8'h2d;
                    {b[4], b[3], b[2], b[1]} = imm;
                    len = 3'd5;
                end
                else
                begin
                    b[0] = 8'h81;
                    b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg,
                        (req.opcode == x86enc_pkg::OP_ADD_RI) ? 3'd0 : 3'd5, r0);
                    {b[5], b[4], b[3], b[2]} = imm;
                    len = 3'd6;
                end
            end
            x86enc_pkg::OP_ADD:  begin b[0] = 8'h03; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r0, r1); end
            x86enc_pkg::OP_AND:  begin b[0] = 8'h23; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r0, r1); end
            x86enc_pkg::OP_OR:   begin b[0] = 8'h0b; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r0, r1); end
            x86enc_pkg::OP_SUB:  begin b[0] = 8'h2b; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r0, r1); end
            x86enc_pkg::OP_TEST: begin b[0] = 8'h85; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r0, r1); end
            x86enc_pkg::OP_XOR:  begin b[0] = 8'h33; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r0, r1); end
            x86enc_pkg::OP_CMP:  begin b[0] = 8'h39; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r1, r0); end
            x86enc_pkg::OP_MOV_R8_R8:
            begin
                b[0] = 8'h88;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r1, r0);
            end
            x86enc_pkg::OP_MOV_RR:
            begin
                b[0] = 8'h89;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r1, r0);
            end
            x86enc_pkg::OP_BSF, x86enc_pkg::OP_BSR:
            begin
                b[0] = x86enc_pkg::PfxTwoByte;
                b[1] = (req.opcode == x86enc_pkg::OP_BSF) ? 8'hbc : 8'hbd;
                b[2] = x86enc_pkg::modrm(x86enc_pkg::ModReg, r0, r1);
                len  = 3'd3;
            end
            x86enc_pkg::OP_CALL_REL, x86enc_pkg::OP_JMP_REL:
            begin
                b[0] = (req.opcode == x86enc_pkg::OP_CALL_REL) ? 8'he8 : 8'he9;
                {b[4], b[3], b[2], b[1]} = rel5;
                len = 3'd5;
            end
            x86enc_pkg::OP_JAE, x86enc_pkg::OP_JB, x86enc_pkg::OP_JZ, x86enc_pkg::OP_JNE:
            begin
                b[0] = x86enc_pkg::PfxTwoByte;
                unique case (x86enc_pkg::opcode_t'(req.opcode))
                    x86enc_pkg::OP_JAE: b[1] = 8'h83;
                    x86enc_pkg::OP_JB:  b[1] = 8'h82;
                    x86enc_pkg::OP_JZ:  b[1] = 8'h84;
                    default:            b[1] = 8'h85;
                endcase
                {b[5], b[4], b[3], b[2]} = rel6;
                len = 3'd6;
            end
            x86enc_pkg::OP_DIV:  begin b[0] = 8'hf7; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd6, r0); end
            x86enc_pkg::OP_IDIV: begin b[0] = 8'hf7; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd7, r0); end
            x86enc_pkg::OP_MUL:  begin b[0] = 8'hf7; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd4, r0); end
            x86enc_pkg::OP_ROL:  begin b[0] = 8'hd3; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd0, r0); end
            x86enc_pkg::OP_ROR:  begin b[0] = 8'hd3; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd1, r0); end
            x86enc_pkg::OP_SAR:  begin b[0] = 8'hd3; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd7, r0); end
            x86enc_pkg::OP_SHR:  begin b[0] = 8'hd3; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd5, r0); end
            x86enc_pkg::OP_SHL:  begin b[0] = 8'hd3; b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd4, r0); end
            x86enc_pkg::OP_SHL_IMM:
            begin
                b[0] = 8'hc1;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd4, r0);
                b[2] = imm[7:0];
                len  = 3'd3;
            end
            x86enc_pkg::OP_MOV_DIS_R:
            begin
                b[0] = 8'h89;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModDisp32, r1, x86enc_pkg::RegEbp);
                {b[5], b[4], b[3], b[2]} = imm;
                len = 3'd6;
            end
            x86enc_pkg::OP_MOV_R_DIS:
            begin
                b[0] = 8'h8b;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModDisp32, r0, x86enc_pkg::RegEbp);
                {b[5], b[4], b[3], b[2]} = imm;
                len = 3'd6;
            end
            x86enc_pkg::OP_MOV_R_AR:
            begin
                b[0] = 8'h8b;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModInd, r0, r1);
            end
            x86enc_pkg::OP_MOV_AR_R8:
            begin
                b[0] = 8'h88;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModInd, r1, r0);
            end
            x86enc_pkg::OP_MOV_AR_R:
            begin
                b[0] = 8'h89;
                b[1] = x86enc_pkg::modrm(x86enc_pkg::ModInd, r1, r0);
            end
            x86enc_pkg::OP_MOV_RI:
            begin
                b[0] = 8'hb8 + {5'd0, r0};
                {b[4], b[3], b[2], b[1]} = imm;
                len = 3'd5;
            end
            x86enc_pkg::OP_MOVSX_AR8, x86enc_pkg::OP_MOVSX_AR16,
            x86enc_pkg::OP_MOVZX_AR8, x86enc_pkg::OP_MOVZX_AR16:
            begin
                b[0] = x86enc_pkg::PfxTwoByte;
                unique case (x86enc_pkg::opcode_t'(req.opcode))
                    x86enc_pkg::OP_MOVSX_AR8:  b[1] = 8'hbe;
                    x86enc_pkg::OP_MOVSX_AR16: b[1] = 8'hbf;
                    x86enc_pkg::OP_MOVZX_AR8:  b[1] = 8'hb6;
                    default:                   b[1] = 8'hb7;
                endcase
                b[2] = x86enc_pkg::modrm(x86enc_pkg::ModInd, r0, r1);
                len  = 3'd3;
            end
            x86enc_pkg::OP_PUSH:
            begin
                b[0] = 8'h50 + {5'd0, r0};
                len  = 3'd1;
                stk  = req.stack_height + 32'd1;
            end
            x86enc_pkg::OP_POP:
            begin
                b[0] = 8'h58 + {5'd0, r0};
                len  = 3'd1;
                stk  = req.stack_height - 32'd1;
            end
            x86enc_pkg::OP_RET:
            begin
                b[0] = 8'hc3;
                len  = 3'd1;
            end
            x86enc_pkg::OP_SETA, x86enc_pkg::OP_SETAE, x86enc_pkg::OP_SETB,
            x86enc_pkg::OP_SETBE, x86enc_pkg::OP_SETG, x86enc_pkg::OP_SETGE,
            x86enc_pkg::OP_SETL, x86enc_pkg::OP_SETLE, x86enc_pkg::OP_SETNE,
            x86enc_pkg::OP_SETZ:
            begin
                b[0] = x86enc_pkg::PfxTwoByte;
                unique case (x86enc_pkg::opcode_t'(req.opcode))
                    x86enc_pkg::OP_SETA:  b[1] = 8'h97;
                    x86enc_pkg::OP_SETAE: b[1] = 8'h93;
                    x86enc_pkg::OP_SETB:  b[1] = 8'h92;
                    x86enc_pkg::OP_SETBE: b[1] = 8'h96;
                    x86enc_pkg::OP_SETG:  b[1] = 8'h9f;
                    x86enc_pkg::OP_SETGE: b[1] = 8'h9d;
                    x86enc_pkg::OP_SETL:  b[1] = 8'h9c;
                    x86enc_pkg::OP_SETLE: b[1] = 8'h9e;
                    x86enc_pkg::OP_SETNE: b[1] = 8'h95;
                    default:              b[1] = 8'h94;
                endcase
                b[2] = x86enc_pkg::modrm(x86enc_pkg::ModReg, 3'd0, r0);
                len  = 3'd3;
            end
            default:
            begin
                // undefined form: NOP
                b[0] = x86enc_pkg::OpNop;
                len  = 3'd1;
            end
        endcase
    end

    assign res.code_bytes   = {b[5], b[4], b[3], b[2], b[1], b[0]};
    assign res.code_length  = len;
    assign res.stack_height = stk;

endmodule
`default_nettype wire

// ===== sv/x86_instruction_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86_instruction_encoder
// Encodes one request per cycle into 1 to 6 IA-32 code bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive opcode, first_reg, second_reg, immediate,
//   start_addr, end_addr and stack_height_in with start high; the item is
//   taken at that clock edge when busy is low. busy is always low, so a
//   new item can be issued every cycle.
//   Result channel: done is high for exactly one cycle with code_bytes
//   (first byte in bits 7:0, unused bytes zero), code_length and
//   stack_height_out. The receiver must take it in that cycle.
//   An accepted item passes the input register, then the result register,
//   before done rises. Throughput: 1 item per cycle, set by the single
//   combinational assembly stage.
//   Reset (rst_n low, asynchronous) drops any item in flight and clears
//   done; the request and result data registers are not reset.
// ----------------------------------------------------------------------------
module x86_instruction_encoder
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [5:0]  opcode,
    input  wire  [2:0]  first_reg,
    input  wire  [2:0]  second_reg,
    input  wire  [31:0] immediate,
    input  wire  [31:0] start_addr,
    input  wire  [31:0] end_addr,
    input  wire  [31:0] stack_height_in,
    output logic        done,
    output logic [47:0] code_bytes,
    output logic [2:0]  code_length,
    output logic [31:0] stack_height_out
);

    x86enc_pkg::req_t req_reg;
    x86enc_pkg::req_t req_next;
    x86enc_pkg::res_t res_reg;
    x86enc_pkg::res_t res_next;
    logic             vld_reg;
    logic             done_reg;

    assign busy = 1'b0;

    always_comb
    begin
        req_next.opcode       = opcode;
        req_next.first_reg    = first_reg;
        req_next.second_reg   = second_reg;
        req_next.immediate    = immediate;
        req_next.start_addr   = start_addr;
        req_next.end_addr     = end_addr;
        req_next.stack_height = stack_height_in;
    end

    x86enc_core u_core
    (
        .req (req_reg),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= start & ~busy;
            done_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            req_reg <= req_next;
        end
        if (vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done             = done_reg;
    assign code_bytes       = res_reg.code_bytes;
    assign code_length      = res_reg.code_length;
    assign stack_height_out = res_reg.stack_height;

endmodule
`default_nettype wire

// ===== sv/x86enc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86enc_checker
// Port-level checks on the encoder: busy low, latency, no spurious done, length range, byte padding.
// ----------------------------------------------------------------------------
module x86enc_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire [47:0] code_bytes,
    input wire [2:0]  code_length
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after accept");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result without an accepted item");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (code_length != 3'd0 && code_length != 3'd7))
        else $error("code length out of range");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && code_length == 3'd1) |-> (code_bytes[47:8] == 40'd0))
        else $error("unused code bytes not zero");

endmodule

bind x86_instruction_encoder x86enc_checker u_x86enc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .code_bytes  (code_bytes),
    .code_length (code_length)
);
`default_nettype wire
